// ----- sv/line_sensor_array_tracker_macros.svh -----
// Assertion macros shared by the line sensor tracker RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef LINE_SENSOR_ARRAY_TRACKER_MACROS_SVH
`define LINE_SENSOR_ARRAY_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lsat_pkg.sv -----
// Types and constants of the line sensor tracker.
// Used by line_sensor_array_tracker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lsat_pkg;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_MEASURE   = 2'd0,
    KIND_CALIBRATE = 2'd1,
    KIND_RESET     = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  // Track states of a result item.
  typedef enum logic [2:0] {
    TRK_NORMAL      = 3'd0,
    TRK_LOST        = 3'd1,
    TRK_ALL_BLACK   = 3'd2,
    TRK_CROSSING    = 3'd3,
    TRK_SHARP_LEFT  = 3'd4,
    TRK_SHARP_RIGHT = 3'd5
  } track_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_ALL_BLACK   = 3'd1;
  localparam logic [2:0] REG_CROSSING    = 3'd2;
  localparam logic [2:0] REG_SHARP_COUNT = 3'd3;
  localparam logic [2:0] REG_SHARP_ERROR = 3'd4;

  localparam logic [9:0]  RAW_MAX     = 10'd1023;
  localparam logic [9:0]  LEVEL_MAX   = 10'd1000;
  localparam logic [13:0] TOTAL_SAT   = 14'd16383;
  localparam logic [4:0]  TALLY_SAT   = 5'd31;
  localparam int          DIV_W       = 29;

endpackage
`default_nettype wire

// ----- sv/lsat_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module lsat_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 14
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read returns the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- sv/line_sensor_array_tracker.sv -----
// Top level of the line sensor tracker: calibration RAM, shared divider, accumulators.
// Depends on lsat_pkg, lsat_ram and line_sensor_array_tracker_macros.svh.
//
// One sample arrives per item with its channel and a kind. Calibrate and reset items pass
// through the accept cycle and the RAM read-data cycle, in which the new min/max is
// written back. A measure sample that can be active goes through accept, RAM read, the
// 29-bit serial divider that normalizes it against the channel's stored min/max, and an
// accumulate state; a sample that cannot be active skips the divider and accumulate.
// On frame end the item goes on through a frame state, a second pass of the same divider
// for the Q8 centroid, a finish state and the output register load, where a full output
// register can hold it; with no active sensor only the frame state and the output load
// are added. The per-channel min/max sit in one RAM with valid bits that make unwritten
// channels read as min 1023, max 0, so no clearing pass is needed after reset. A result
// waits in an output register; the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "line_sensor_array_tracker_macros.svh"
module line_sensor_array_tracker #(
  parameter int SENSOR_COUNT = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // channel[3:0], sample[13:4], zero[15:14]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  input  wire logic        s_tlast,   // frame_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // position_error[15:0], track_state[18:16],
                                      // active_count[23:19]
  output logic      [0:0]  m_tuser,   // error_held[0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(SENSOR_COUNT);
  localparam int W0 = 5 * (SENSOR_COUNT - 1);
  localparam int DW = lsat_pkg::DIV_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_READ = 8'b00000010,
    ST_NDIV = 8'b00000100,
    ST_ACC  = 8'b00001000,
    ST_FEND = 8'b00010000,
    ST_FDIV = 8'b00100000,
    ST_FIN  = 8'b01000000,
    ST_OUT  = 8'b10000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [9:0]  active_threshold;
  logic [4:0]  all_black_count;
  logic [4:0]  crossing_count;
  logic [4:0]  sharp_turn_count;
  logic [14:0] sharp_err_limit;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_threshold <= 10'd500;
      all_black_count  <= 5'd12;
      crossing_count   <= 5'd6;
      sharp_turn_count <= 5'd3;
      sharp_err_limit  <= 15'd7680;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        lsat_pkg::REG_THRESHOLD:   active_threshold <= pwdata[9:0];
        lsat_pkg::REG_ALL_BLACK:   all_black_count  <= pwdata[4:0];
        lsat_pkg::REG_CROSSING:    crossing_count   <= pwdata[4:0];
        lsat_pkg::REG_SHARP_COUNT: sharp_turn_count <= pwdata[4:0];
        lsat_pkg::REG_SHARP_ERROR: sharp_err_limit  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[4:2])
      lsat_pkg::REG_THRESHOLD:   prdata = {22'd0, active_threshold};
      lsat_pkg::REG_ALL_BLACK:   prdata = {27'd0, all_black_count};
      lsat_pkg::REG_CROSSING:    prdata = {27'd0, crossing_count};
      lsat_pkg::REG_SHARP_COUNT: prdata = {27'd0, sharp_turn_count};
      lsat_pkg::REG_SHARP_ERROR: prdata = {17'd0, sharp_err_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  // Captured item.
  lsat_pkg::kind_t kind;
  logic [3:0]      channel;
  logic [9:0]      sample;
  logic            frame_end;
  logic            in_range;
  logic            accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_range = ({1'b0, channel} < 5'(SENSOR_COUNT));

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= lsat_pkg::kind_t'(s_tuser);
      channel   <= s_tdata[3:0];
      sample    <= s_tdata[13:4];
      frame_end <= s_tlast;
    end
  end

  // Calibration RAM: {max, min} per channel, with valid bits for reset values.
  logic [SENSOR_COUNT-1:0] cal_valid;
  logic [AW-1:0]           ram_addr;
  logic                    ram_we;
  logic [19:0]             ram_wdata;
  logic [19:0]             ram_rdata;
  logic [9:0]              lo;
  logic [9:0]              hi;

  assign ram_addr = accept ? s_tdata[AW-1:0] : channel[AW-1:0];

  lsat_ram #(.WIDTH(20), .DEPTH(SENSOR_COUNT)) u_cal_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign lo = cal_valid[channel[AW-1:0]] ? ram_rdata[9:0]   : lsat_pkg::RAW_MAX;
  assign hi = cal_valid[channel[AW-1:0]] ? ram_rdata[19:10] : 10'd0;

  // Write back calibration in the read-data cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {10'd0, lsat_pkg::RAW_MAX};
    if (state == ST_READ && in_range) begin
      if (kind == lsat_pkg::KIND_CALIBRATE) begin
        ram_we    = 1'b1;
        ram_wdata = {(sample > hi) ? sample : hi, (sample < lo) ? sample : lo};
      end else if (kind == lsat_pkg::KIND_RESET) begin
        ram_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_valid <= '0;
    end else if (ram_we) begin
      cal_valid[channel[AW-1:0]] <= 1'b1;
    end
  end

  // Shared restoring divider, one quotient bit a cycle.
  logic [DW-1:0] div_num;
  logic [DW-1:0] div_quo;
  logic [13:0]   div_rem;
  logic [13:0]   div_den;
  logic [4:0]    div_cnt;
  logic [14:0]   div_trial;
  logic          div_ge;
  logic          div_load;
  logic [DW-1:0] div_load_num;
  logic [13:0]   div_load_den;

  assign div_trial = {div_rem, div_num[DW-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_num <= div_load_num;
      div_den <= div_load_den;
      div_rem <= '0;
      div_quo <= '0;
      div_cnt <= 5'(DW - 1);
    end else if (state == ST_NDIV || state == ST_FDIV) begin
      div_num <= {div_num[DW-2:0], 1'b0};
      div_rem <= div_ge ? 14'(div_trial - {1'b0, div_den}) : div_trial[13:0];
      div_quo <= {div_quo[DW-2:0], div_ge};
      div_cnt <= div_cnt - 5'd1;
    end
  end

  // Accumulators and held error.
  logic signed [20:0] weighted_accumulator;
  logic [13:0]        level_total;
  logic [4:0]         active_tally;
  logic signed [15:0] held_error;
  logic [9:0]         level;
  logic signed [8:0]  weight;
  logic signed [19:0] product;
  logic signed [21:0] acc_sum;
  logic [14:0]        total_sum;
  logic [28:0]        acc_mag;

  assign level     = (div_quo > DW'(lsat_pkg::LEVEL_MAX)) ? lsat_pkg::LEVEL_MAX
                                                            : div_quo[9:0];
  assign weight    = 9'(W0) - 9'(10 * channel);
  assign product   = 20'(weight) * 20'($signed({1'b0, level}));
  assign acc_sum   = 22'(weighted_accumulator) + 22'(product);
  assign total_sum = {1'b0, level_total} + {5'd0, level};
  // Magnitude of the sum scaled by 256; the full range needs 21 bits before the shift.
  assign acc_mag   = weighted_accumulator[20] ? {21'(-22'(weighted_accumulator)), 8'd0}
                                              : {weighted_accumulator[20:0], 8'd0};

  // Signed clamp and track state of the centroid.
  logic signed [15:0] err_c;
  logic signed [16:0] err_x;
  lsat_pkg::track_t   trk_c;
  logic               sharp_ok;

  always_comb begin
    if (weighted_accumulator[20]) begin
      err_c = (div_quo > DW'(32768)) ? 16'sh8000 : 16'(-div_quo);
    end else begin
      err_c = (div_quo > DW'(32767)) ? 16'sh7fff : div_quo[15:0];
    end
    err_x    = 17'(err_c);
    sharp_ok = (active_tally >= sharp_turn_count);
    priority if (active_tally >= all_black_count) trk_c = lsat_pkg::TRK_ALL_BLACK;
    else if (active_tally >= crossing_count)      trk_c = lsat_pkg::TRK_CROSSING;
    else if (sharp_ok && err_x < -$signed({2'b0, sharp_err_limit}))
                                                  trk_c = lsat_pkg::TRK_SHARP_LEFT;
    else if (sharp_ok && err_x > $signed({2'b0, sharp_err_limit}))
                                                  trk_c = lsat_pkg::TRK_SHARP_RIGHT;
    else                                          trk_c = lsat_pkg::TRK_NORMAL;
  end

  // Pending result, loaded into the output register in ST_OUT.
  logic [15:0]      res_error;
  lsat_pkg::track_t res_track;
  logic [4:0]       res_count;
  logic             res_held;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;

  // Divider load selection.
  always_comb begin
    div_load     = 1'b0;
    div_load_num = DW'((20'(sample - lo)) * 20'd1000);
    div_load_den = {4'd0, 10'(hi - lo)};
    if (state == ST_READ && kind == lsat_pkg::KIND_MEASURE && in_range
        && lo < hi && sample > lo) begin
      div_load = 1'b1;
    end else if (state == ST_FEND && active_tally != 5'd0) begin
      div_load     = 1'b1;
      div_load_num = acc_mag;
      div_load_den = level_total;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      weighted_accumulator <= '0;
      level_total          <= '0;
      active_tally         <= '0;
      held_error           <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser != lsat_pkg::KIND_UNUSED) state <= ST_READ;
        end
        ST_READ: begin
          if (kind != lsat_pkg::KIND_MEASURE) state <= ST_IDLE;
          else if (div_load)                  state <= ST_NDIV;
          else if (frame_end)                 state <= ST_FEND;
          else                                state <= ST_IDLE;
        end
        ST_NDIV: begin
          if (div_cnt == 5'd0) state <= ST_ACC;
        end
        ST_ACC: begin
          if (level > active_threshold) begin
            if (acc_sum > 22'sd1048575)       weighted_accumulator <= 21'sd1048575;
            else if (acc_sum < -22'sd1048576) weighted_accumulator <= -21'sd1048576;
            else                              weighted_accumulator <= acc_sum[20:0];
            level_total <= total_sum[14] ? lsat_pkg::TOTAL_SAT : total_sum[13:0];
            if (active_tally != lsat_pkg::TALLY_SAT) active_tally <= active_tally + 5'd1;
          end
          state <= frame_end ? ST_FEND : ST_IDLE;
        end
        ST_FEND: begin
          if (active_tally == 5'd0) begin
            res_error <= held_error;
            res_track <= lsat_pkg::TRK_LOST;
            res_count <= 5'd0;
            res_held  <= 1'b1;
            state     <= ST_OUT;
          end else begin
            state <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          if (div_cnt == 5'd0) state <= ST_FIN;
        end
        ST_FIN: begin
          res_error            <= err_c;
          res_track            <= trk_c;
          res_count            <= active_tally;
          res_held             <= 1'b0;
          held_error           <= err_c;
          weighted_accumulator <= '0;
          level_total          <= '0;
          active_tally         <= '0;
          state                <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {res_count, res_track, res_error};
      m_tuser <= res_held;
    end
  end

  // Checks on sequencing.
  `LSAT_ASSERT_NXT(a_out_loads, state == ST_OUT && out_free, m_tvalid,
    "result not presented after output load")
  `LSAT_ASSERT_NXT(a_ndiv_done, state == ST_NDIV && div_cnt == 5'd0, state == ST_ACC,
    "normalize division did not hand over to accumulate")
  `LSAT_ASSERT_IMP(a_held_lost, m_tvalid && m_tuser[0],
    m_tdata[18:16] == lsat_pkg::TRK_LOST, "held error without line lost state")
  `LSAT_ASSERT_IMP(a_div_idle, s_tready, !(state == ST_NDIV || state == ST_FDIV),
    "input ready while divider busy")

endmodule
`default_nettype wire

// ----- sim/line_sensor_array_tracker_test.sv -----
// Self-checking testbench for the line sensor tracker: calibrates channels, streams
// measure frames and checks every centroid result against an in-bench predictor.
// Depends on lsat_pkg and line_sensor_array_tracker.
`timescale 1ns / 1ps
module line_sensor_array_tracker_test;

  localparam int NSENS = 14;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // channel[3:0], sample[13:4], zero[15:14]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // position_error[15:0], track_state[18:16], active_count[23:19]
  logic [0:0]  m_tuser;        // error_held[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_sensor_array_tracker #(.SENSOR_COUNT(NSENS)) dut (.*);

  always #1 clk = ~clk;

  // One centroid result.
  typedef struct packed {
    logic signed [15:0] err;
    logic [2:0]         state;
    logic [4:0]         count;
    logic               held;
  } centroid_t;

  centroid_t centroid_q[$];
  int errors = 0;
  int frames_seen = 0;
  int items_sent = 0;
  bit stall_free = 0;

  // Predictor copy of the block's registers and state.
  int thr_r, black_r, cross_r, sharp_cnt_r, sharp_err_r;
  int cal_min[16], cal_max[16];
  int acc_sum, lvl_sum, act_num, last_err;

  function automatic void model_reset();
    thr_r = 500; black_r = 12; cross_r = 6; sharp_cnt_r = 3; sharp_err_r = 7680;
    for (int i = 0; i < 16; i++) begin
      cal_min[i] = 1023;
      cal_max[i] = 0;
    end
    acc_sum = 0; lvl_sum = 0; act_num = 0; last_err = 0;
  endfunction

  // Advance the predictor by one item and queue a result on a measure item's frame end.
  function automatic void predict_centroid(lsat_pkg::kind_t k, int ch, int raw, bit fend);
    int lvl, w;
    longint q;
    centroid_t r;
    bit ok;
    ok = ch < NSENS;
    if (k == lsat_pkg::KIND_CALIBRATE) begin
      if (ok) begin
        if (raw < cal_min[ch]) cal_min[ch] = raw;
        if (raw > cal_max[ch]) cal_max[ch] = raw;
      end
      return;
    end
    if (k == lsat_pkg::KIND_RESET) begin
      if (ok) begin
        cal_min[ch] = 1023;
        cal_max[ch] = 0;
      end
      return;
    end
    if (k != lsat_pkg::KIND_MEASURE) return;
    if (ok) begin
      if (cal_min[ch] >= cal_max[ch]) lvl = 0;
      else lvl = ((raw - cal_min[ch]) * 1000) / (cal_max[ch] - cal_min[ch]);
      if (lvl < 0) lvl = 0;
      if (lvl > 1000) lvl = 1000;
      if (lvl > thr_r) begin
        w = 5 * (NSENS - 1) - 10 * ch;
        acc_sum += w * lvl;
        if (acc_sum > 1048575) acc_sum = 1048575;
        if (acc_sum < -1048576) acc_sum = -1048576;
        lvl_sum += lvl;
        if (lvl_sum > 16383) lvl_sum = 16383;
        if (act_num < 31) act_num++;
      end
    end
    if (!fend) return;
    r.count = act_num[4:0];
    if (act_num == 0) begin
      r.err = last_err[15:0];
      r.held = 1'b1;
      r.state = lsat_pkg::TRK_LOST;
    end else begin
      q = (longint'(acc_sum) * 256) / longint'(lvl_sum);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      last_err = int'(q);
      r.err = last_err[15:0];
      r.held = 1'b0;
      if (act_num >= black_r) r.state = lsat_pkg::TRK_ALL_BLACK;
      else if (act_num >= cross_r) r.state = lsat_pkg::TRK_CROSSING;
      else if (act_num >= sharp_cnt_r && last_err < -sharp_err_r)
        r.state = lsat_pkg::TRK_SHARP_LEFT;
      else if (act_num >= sharp_cnt_r && last_err > sharp_err_r)
        r.state = lsat_pkg::TRK_SHARP_RIGHT;
      else r.state = lsat_pkg::TRK_NORMAL;
    end
    acc_sum = 0; lvl_sum = 0; act_num = 0;
    centroid_q.push_back(r);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Send one item and update the predictor once it is accepted.
  // The first falling edge keeps the new item apart from the previous one's release.
  task automatic send_item(lsat_pkg::kind_t k, int ch, int raw, bit fend);
    int g;
    g = stall_free ? 0 : gap_len();
    repeat (g + 1) @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {2'b00, raw[9:0], ch[3:0]};
    s_tlast  <= fend;
    do @(posedge clk); while (!s_tready);
    predict_centroid(k, ch, raw, fend);
    items_sent++;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Register write: setup then access cycle.
  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      lsat_pkg::REG_THRESHOLD:   thr_r = val & 'h3ff;
      lsat_pkg::REG_ALL_BLACK:   black_r = val & 'h1f;
      lsat_pkg::REG_CROSSING:    cross_r = val & 'h1f;
      lsat_pkg::REG_SHARP_COUNT: sharp_cnt_r = val & 'h1f;
      default:                   sharp_err_r = val & 'h7fff;
    endcase
  endtask

  // Let the block drain before touching registers.
  task automatic wait_idle();
    while (centroid_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Receiver: random stalls outside the stall-free phase, checks each result against the oldest expectation.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= stall_free ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    centroid_t e;
    if (!rst && m_tvalid && m_tready) begin
      frames_seen++;
      if (centroid_q.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        e = centroid_q.pop_front();
        if (m_tdata[15:0] !== e.err) begin
          $error("position_error expected %0d got %0d", e.err, $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[18:16] !== e.state) begin
          $error("track_state expected %0d got %0d", e.state, m_tdata[18:16]);
          errors++;
        end
        if (m_tdata[23:19] !== e.count) begin
          $error("active_count expected %0d got %0d", e.count, m_tdata[23:19]);
          errors++;
        end
        if (m_tuser[0] !== e.held) begin
          $error("error_held expected %0d got %0d", e.held, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Calibrate every channel, over the full range or with a random spread.
  task automatic calibrate_all(bit full);
    for (int c = 0; c < NSENS; c++) begin
      send_item(lsat_pkg::KIND_CALIBRATE, c, full ? 0 : $urandom_range(0, 300), 0);
      send_item(lsat_pkg::KIND_CALIBRATE, c, full ? 1023 : $urandom_range(600, 1023), 0);
    end
  endtask

  // Directed corners: extremes, every kind, out-of-range channel, stray frame ends.
  task automatic test_directed();
    send_item(lsat_pkg::KIND_MEASURE, 0, 1023, 1);     // uncalibrated: line lost, held zero
    send_item(lsat_pkg::KIND_CALIBRATE, 0, 0, 0);
    send_item(lsat_pkg::KIND_CALIBRATE, 0, 1023, 0);
    send_item(lsat_pkg::KIND_CALIBRATE, 13, 100, 0);
    send_item(lsat_pkg::KIND_CALIBRATE, 13, 900, 0);
    send_item(lsat_pkg::KIND_CALIBRATE, 15, 5, 1);     // out of range, frame end ignored
    send_item(lsat_pkg::KIND_UNUSED, 3, 1023, 1);      // ignored kind
    send_item(lsat_pkg::KIND_MEASURE, 0, 1023, 1);     // far left only
    send_item(lsat_pkg::KIND_MEASURE, 13, 1023, 1);    // clamp above max, far right
    send_item(lsat_pkg::KIND_MEASURE, 13, 0, 1);       // clamp below min, held error
    send_item(lsat_pkg::KIND_MEASURE, 14, 1023, 1);    // out-of-range measure still ends frame
    send_item(lsat_pkg::KIND_MEASURE, 0, 1023, 0);
    send_item(lsat_pkg::KIND_MEASURE, 13, 1023, 1);    // balanced-ish pair
    send_item(lsat_pkg::KIND_RESET, 0, 0, 1);
    send_item(lsat_pkg::KIND_RESET, 15, 1023, 0);
    send_item(lsat_pkg::KIND_MEASURE, 0, 1023, 1);     // reset channel reads zero
    send_item(lsat_pkg::KIND_MEASURE, 13, 682, 1);
    // Repeated channel to saturate the total, though not the tally.
    for (int i = 0; i < 20; i++) send_item(lsat_pkg::KIND_MEASURE, 13, 1023, i == 19);
  endtask

  // Register extremes with a short frame mix under each.
  task automatic test_registers();
    int sets[4][5] = '{'{0, 0, 0, 0, 0}, '{1000, 16, 16, 16, 16640},
                       '{1023, 31, 31, 31, 32767}, '{200, 10, 5, 1, 500}};
    for (int s = 0; s < 4; s++) begin
      wait_idle();
      write_reg(lsat_pkg::REG_THRESHOLD, sets[s][0]);
      write_reg(lsat_pkg::REG_ALL_BLACK, sets[s][1]);
      write_reg(lsat_pkg::REG_CROSSING, sets[s][2]);
      write_reg(lsat_pkg::REG_SHARP_COUNT, sets[s][3]);
      write_reg(lsat_pkg::REG_SHARP_ERROR, sets[s][4]);
      calibrate_all(1);
      for (int f = 0; f < 8; f++) random_frame();
    end
  endtask

  // One frame: mostly a sweep of channels, sometimes a broken or partial one.
  task automatic random_frame();
    int n, mode;
    mode = $urandom_range(0, 9);
    n = (mode < 7) ? NSENS : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      int ch;
      ch = (mode < 7) ? i : $urandom_range(0, 15);
      if ($urandom_range(0, 30) == 0)
        send_item(lsat_pkg::kind_t'($urandom_range(1, 3)), ch, $urandom_range(0, 1023),
                  $urandom_range(0, 1) == 1);
      else
        send_item(lsat_pkg::KIND_MEASURE, ch, $urandom_range(0, 1023), i == n - 1);
    end
  endtask

  // Random phase with several register settings.
  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_reg(lsat_pkg::REG_THRESHOLD, $urandom_range(100, 900));
      write_reg(lsat_pkg::REG_ALL_BLACK, $urandom_range(4, 16));
      write_reg(lsat_pkg::REG_CROSSING, $urandom_range(2, 10));
      write_reg(lsat_pkg::REG_SHARP_COUNT, $urandom_range(1, 5));
      write_reg(lsat_pkg::REG_SHARP_ERROR, $urandom_range(0, 16640));
      calibrate_all($urandom_range(0, 1) == 1);
      stall_free = (p == 2);
      for (int f = 0; f < 10; f++) random_frame();
      stall_free = 0;
    end
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_random();
    while (centroid_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d items, checked %0d centroid results over several register settings.",
             items_sent, frames_seen);
    if (errors == 0 && centroid_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lsat_pkg.sv
sv/lsat_ram.sv
sv/line_sensor_array_tracker.sv
sim/line_sensor_array_tracker_test.sv
